// ----- rtl/htlp_pkg.sv -----
// Package for the linear-probing hash table: word types, status codes,
// widths and layout of the command queue entry. No dependencies.
package htlp_pkg;

  // Default geometry
  localparam int DEF_TABLE_SLOTS = 32;
  localparam int DEF_KEY_CHARS   = 8;

  // Fixed field widths
  localparam int KEY_W      = 64;
  localparam int LEN_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 5;
  localparam int MAX_CHARS  = 8;

  // Widest hash sum: 255 * (1 + 2 + ... + 8) = 9180
  localparam int SUM_W = 14;

  // Command queue depth between front and back
  localparam int Q_DEPTH = 2;

  // Command queue entry layout: {home, len, key, empty, kind}
  localparam int QE_KIND    = 0;
  localparam int QE_EMPTY   = 1;
  localparam int QE_KEY     = 2;
  localparam int QE_LEN     = QE_KEY + KEY_W;
  localparam int QE_HOME    = QE_LEN + LEN_W;

  // Request kinds
  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY_KEY = 3'd4
  } status_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key_chars;
    logic [LEN_W-1:0] key_length;
  } in_word_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot_index;
  } out_word_t;

endpackage

// ----- rtl/htlp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/htlp_front.sv -----
// Front part: takes request words, masks the key, computes the home slot
// over three pipeline stages and pushes commands to the queue. Uses htlp_pkg.
module htlp_front #(
  parameter int TABLE_SLOTS = htlp_pkg::DEF_TABLE_SLOTS,
  parameter int KEY_CHARS   = htlp_pkg::DEF_KEY_CHARS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  take,
  input  htlp_pkg::in_word_t                    in_word,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [htlp_pkg::QE_HOME+$clog2(TABLE_SLOTS)-1:0] q_data,
  output logic                                  stall
);

  localparam int IDX_W    = $clog2(TABLE_SLOTS);
  localparam int KEY_W    = htlp_pkg::KEY_W;
  localparam int LEN_W    = htlp_pkg::LEN_W;
  localparam int SUM_W    = htlp_pkg::SUM_W;
  localparam int RECIP_SH = 24;
  localparam int RECIP    = (1 << RECIP_SH) / TABLE_SLOTS;
  localparam int PROD_W   = SUM_W + RECIP_SH;

  // Stage registers
  logic             s1_v_r, s2_v_r, s3_v_r;
  logic             s1_kind_r, s2_kind_r, s3_kind_r;
  logic             s1_empty_r, s2_empty_r, s3_empty_r;
  logic [KEY_W-1:0] s1_key_r, s2_key_r, s3_key_r;
  logic [LEN_W-1:0] s1_len_r, s2_len_r, s3_len_r;
  logic [SUM_W-1:0] s1_sum_r, s2_sum_r, s3_sum_r;
  logic [SUM_W-1:0] s2_q_r;
  logic [SUM_W-1:0] s3_qd_r;

  logic             en;
  logic [LEN_W-1:0] len_eff;
  logic [KEY_W-1:0] key_m;
  logic [SUM_W-1:0] sum;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0] rem, rem_fix;

  // Pipeline moves when the last stage is empty or can push
  assign en     = !s3_v_r || !q_full;
  assign stall  = !en;
  assign q_push = s3_v_r && !q_full;

  // Clamp length, mask key bytes and weight each byte by its position
  always_comb begin
    len_eff = (in_word.key_length > LEN_W'(KEY_CHARS)) ? LEN_W'(KEY_CHARS)
                                                        : in_word.key_length;
    key_m = '0;
    sum   = '0;
    for (int i = 0; i < htlp_pkg::MAX_CHARS; i++) begin
      if (LEN_W'(i) < len_eff) begin
        key_m[8*i +: 8] = in_word.key_chars[8*i +: 8];
        sum = sum + SUM_W'(in_word.key_chars[8*i +: 8]) * SUM_W'(i + 1);
      end
    end
  end

  // Quotient estimate by reciprocal, at most one low
  assign prod = PROD_W'(s1_sum_r) * PROD_W'(RECIP);

  // Remainder with one correction step
  always_comb begin
    rem     = s3_sum_r - s3_qd_r;
    rem_fix = (rem >= SUM_W'(TABLE_SLOTS)) ? rem - SUM_W'(TABLE_SLOTS) : rem;
  end

  assign q_data = {IDX_W'(rem_fix), s3_len_r, s3_key_r, s3_empty_r, s3_kind_r};

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r  <= in_word.kind;
      s1_empty_r <= (len_eff == '0);
      s1_key_r   <= key_m;
      s1_len_r   <= len_eff;
      s1_sum_r   <= sum;

      s2_kind_r  <= s1_kind_r;
      s2_empty_r <= s1_empty_r;
      s2_key_r   <= s1_key_r;
      s2_len_r   <= s1_len_r;
      s2_sum_r   <= s1_sum_r;
      s2_q_r     <= SUM_W'(prod >> RECIP_SH);

      s3_kind_r  <= s2_kind_r;
      s3_empty_r <= s2_empty_r;
      s3_key_r   <= s2_key_r;
      s3_len_r   <= s2_len_r;
      s3_sum_r   <= s2_sum_r;
      s3_qd_r    <= s2_q_r * SUM_W'(TABLE_SLOTS);
    end
  end

endmodule

// ----- rtl/htlp_queue.sv -----
// Short command queue between the front and the back parts.
// Uses htlp_pkg for its depth.
module htlp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         not_empty
);

  localparam int DEPTH = htlp_pkg::Q_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = ent_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/htlp_back.sv -----
// Back part: clears the slot memory after reset, then probes it one slot
// a cycle per command and drives the result word. Uses htlp_pkg, htlp_ram.
module htlp_back #(
  parameter int TABLE_SLOTS = htlp_pkg::DEF_TABLE_SLOTS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_not_empty,
  input  logic [htlp_pkg::QE_HOME+$clog2(TABLE_SLOTS)-1:0] q_data,
  output logic                                  q_pop,
  output logic                                  clearing,
  output logic                                  out_strobe,
  output htlp_pkg::out_word_t                   out_word
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = htlp_pkg::KEY_W;
  localparam int LEN_W  = htlp_pkg::LEN_W;
  localparam int OUT_W  = htlp_pkg::SLOT_OUT_W;
  localparam int EXT_W  = (IDX_W > OUT_W) ? IDX_W : OUT_W;
  localparam int ENT_W  = 1 + LEN_W + KEY_W;

  typedef enum logic [2:0] {
    B_CLR  = 3'b001,
    B_IDLE = 3'b010,
    B_CHK  = 3'b100
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             kind_r, kind_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  htlp_pkg::out_word_t out_word_r, out_word_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr, idx_inc;
  logic [ENT_W-1:0] wdata, rdata;
  logic             rd_used, rd_match;
  logic [EXT_W-1:0] idx_ext;

  // Head of queue fields
  logic             h_kind, h_empty;
  logic [KEY_W-1:0] h_key;
  logic [LEN_W-1:0] h_len;
  logic [IDX_W-1:0] h_home;

  assign h_kind  = q_data[htlp_pkg::QE_KIND];
  assign h_empty = q_data[htlp_pkg::QE_EMPTY];
  assign h_key   = q_data[htlp_pkg::QE_KEY +: KEY_W];
  assign h_len   = q_data[htlp_pkg::QE_LEN +: LEN_W];
  assign h_home  = q_data[htlp_pkg::QE_HOME +: IDX_W];

  // Slot memory entry: {used, length, key}
  htlp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_used  = rdata[ENT_W-1];
  assign rd_match = (rdata[KEY_W +: LEN_W] == len_r) && (rdata[KEY_W-1:0] == key_r);
  assign idx_inc  = (idx_r == IDX_W'(TABLE_SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign idx_ext  = EXT_W'(idx_r);

  assign clearing   = (state_r == B_CLR);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    q_pop          = 1'b0;
    we             = 1'b0;
    waddr          = idx_r;
    wdata          = {1'b1, len_r, key_r};
    raddr          = idx_inc;

    unique case (state_r)
      B_CLR: begin
        we          = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(TABLE_SLOTS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        raddr = h_home;
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (h_empty) begin
            out_strobe_nxt = 1'b1;
            out_word_nxt   = '{status: htlp_pkg::ST_EMPTY_KEY, slot_index: '0};
          end else begin
            kind_nxt  = h_kind;
            key_nxt   = h_key;
            len_nxt   = h_len;
            idx_nxt   = h_home;
            cnt_nxt   = '0;
            state_nxt = B_CHK;
          end
        end
      end
      B_CHK: begin
        // Next slot is read ahead while this one is checked
        if (!rd_used && kind_r == htlp_pkg::KIND_INSERT) begin
          we             = 1'b1;
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{status: htlp_pkg::ST_INSERTED,
                             slot_index: idx_ext[OUT_W-1:0]};
          state_nxt      = B_IDLE;
        end else if (!rd_used) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{status: htlp_pkg::ST_NOT_FOUND, slot_index: '0};
          state_nxt      = B_IDLE;
        end else if (kind_r == htlp_pkg::KIND_SEARCH && rd_match) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{status: htlp_pkg::ST_FOUND,
                             slot_index: idx_ext[OUT_W-1:0]};
          state_nxt      = B_IDLE;
        end else if (cnt_r == IDX_W'(TABLE_SLOTS - 1)) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{status: (kind_r == htlp_pkg::KIND_INSERT) ?
                                     htlp_pkg::ST_FULL : htlp_pkg::ST_NOT_FOUND,
                             slot_index: '0};
          state_nxt      = B_IDLE;
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_CLR;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Command and result payload
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    len_r      <= len_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ----- rtl/hash_table_linear_probing.sv -----
// Linear-probing hash table. A word passes the front stages and the command
// queue to the back part, which probes P slots (1 to TABLE_SLOTS) before it
// raises the result strobe; an empty key probes no slot. The probe loop in
// the back part sets throughput, one slot memory read per cycle, while the
// front and the queue can take new words. The result is strobed for one cycle.
// Reset: a clearing pass over all TABLE_SLOTS slots holds busy high.
module hash_table_linear_probing #(
  parameter int TABLE_SLOTS = htlp_pkg::DEF_TABLE_SLOTS,
  parameter int KEY_CHARS   = htlp_pkg::DEF_KEY_CHARS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  htlp_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output htlp_pkg::out_word_t out_word
);

  localparam int QW = htlp_pkg::QE_HOME + $clog2(TABLE_SLOTS);

  logic          front_stall, clearing;
  logic          q_push, q_pop, q_full, q_not_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  assign busy = front_stall || clearing;

  // Hashing front end
  htlp_front #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_CHARS   (KEY_CHARS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (start && !busy),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .stall   (front_stall)
  );

  // Command queue
  htlp_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Probe engine and slot memory
  htlp_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_strobe  (out_strobe),
    .out_word    (out_word)
  );

  // No result comes out of the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !out_strobe)
    else $error("result strobed during clearing pass");

  // The front never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push into full command queue");

  // Misses carry slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_word.status == htlp_pkg::ST_NOT_FOUND ||
                    out_word.status == htlp_pkg::ST_FULL ||
                    out_word.status == htlp_pkg::ST_EMPTY_KEY))
    |-> (out_word.slot_index == '0))
    else $error("non-zero slot on a miss");

  // Nothing popped while clearing
  assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

endmodule

// ----- sim/tb.sv -----
// Testbench for the linear-probing hash table: drives search and insert words,
// mirrors the slot table to predict each result and checks every strobed word.
// Depends on htlp_pkg and hash_table_linear_probing.
`timescale 1ns / 100ps

module tb;

  localparam int SLOTS        = htlp_pkg::DEF_TABLE_SLOTS;
  localparam int CHARS        = htlp_pkg::DEF_KEY_CHARS;
  localparam int KEY_W        = htlp_pkg::KEY_W;
  localparam int LEN_W        = htlp_pkg::LEN_W;
  localparam int SLOT_W       = htlp_pkg::SLOT_OUT_W;
  localparam int MAX_CHARS    = htlp_pkg::MAX_CHARS;
  localparam int N_WORDS      = 650;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_WORDS  = 80;
  // Word counts at which the sender waits for the table to go quiet
  localparam int HOLD_A       = 300;
  localparam int HOLD_B       = 470;

  // Few byte values, to provoke collisions and zero characters
  localparam logic [7:0] ALPHABET [4] = '{8'h00, 8'h01, 8'h20, 8'hFF};

  // Sender idle percentage per phase; the receiver cannot stall, so the
  // phases at zero run with no sender gaps at all
  localparam int IDLE_PLAN [4] = '{0, 70, 0, 25};

  // Copy of the slot table, with the results still owed by the block
  class table_mirror;
    logic [KEY_W-1:0]    key_mem [SLOTS];
    logic [LEN_W-1:0]    len_mem [SLOTS];
    bit                  used    [SLOTS];
    htlp_pkg::out_word_t due_words [$];
    int                  errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      errors = 0;
    endfunction

    // Work out the result of an accepted word and update the table copy
    function void note_word(htlp_pkg::in_word_t w);
      logic [KEY_W-1:0]    key;
      int unsigned         len;
      int unsigned         idx;
      htlp_pkg::out_word_t res;
      len = (w.key_length > CHARS) ? CHARS : w.key_length;
      key = '0;
      for (int i = 0; i < len; i++) key[8*i +: 8] = w.key_chars[8*i +: 8];
      // home slot: running weighted byte sum, reduced every step
      idx = 0;
      for (int i = 0; i < len; i++) idx = (idx + key[8*i +: 8] * (i + 1)) % SLOTS;
      res.status     = htlp_pkg::ST_EMPTY_KEY;
      res.slot_index = '0;
      if (len != 0) begin
        if (w.kind == htlp_pkg::KIND_INSERT) begin
          res.status = htlp_pkg::ST_FULL;
          for (int n = 0; n < SLOTS; n++) begin
            if (!used[idx]) begin
              used[idx]      = 1'b1;
              key_mem[idx]   = key;
              len_mem[idx]   = LEN_W'(len);
              res.status     = htlp_pkg::ST_INSERTED;
              res.slot_index = idx[SLOT_W-1:0];
              break;
            end
            idx = (idx + 1) % SLOTS;
          end
        end else begin
          res.status = htlp_pkg::ST_NOT_FOUND;
          for (int n = 0; n < SLOTS; n++) begin
            if (!used[idx]) break;
            if (len_mem[idx] == len && key_mem[idx] == key) begin
              res.status     = htlp_pkg::ST_FOUND;
              res.slot_index = idx[SLOT_W-1:0];
              break;
            end
            idx = (idx + 1) % SLOTS;
          end
        end
      end
      due_words = {due_words, res};
    endfunction

    // Compare a strobed result with the oldest one owed
    function void check_word(htlp_pkg::out_word_t got);
      htlp_pkg::out_word_t want;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected result, status %0d slot %0d",
                 $time, got.status, got.slot_index);
        errors++;
        return;
      end
      want = due_words.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.slot_index !== want.slot_index) begin
        $display("%0t: slot_index mismatch, expected %0d actual %0d",
                 $time, want.slot_index, got.slot_index);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  htlp_pkg::in_word_t  in_word = '0;
  logic                out_strobe;
  htlp_pkg::out_word_t out_word;

  table_mirror        mirror = new();
  htlp_pkg::in_word_t inserted_q [$];
  int                 sent = 0;
  int                 idle_pct = 0;
  int                 quiet_cycles = 0;

  hash_table_linear_probing #(
    .TABLE_SLOTS(SLOTS),
    .KEY_CHARS  (CHARS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Results are held for one cycle only; take them at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) mirror.check_word(out_word);
  end

  // Watchdog on cycles with neither an accepted word nor a result
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic htlp_pkg::in_word_t word_of(logic kind, logic [KEY_W-1:0] key,
                                                 logic [LEN_W-1:0] len);
    htlp_pkg::in_word_t w;
    w.kind       = kind;
    w.key_chars  = key;
    w.key_length = len;
    return w;
  endfunction

  // Random key: mostly 1..8 characters, now and then empty or overlong
  function automatic htlp_pkg::in_word_t fresh_word(logic kind);
    htlp_pkg::in_word_t w;
    int unsigned        r;
    int                 eff;
    r            = $urandom_range(19);
    w.kind       = kind;
    w.key_chars  = {$urandom, $urandom};
    if (r == 0)      w.key_length = '0;
    else if (r == 1) w.key_length = LEN_W'($urandom_range(15, 9));
    else             w.key_length = LEN_W'($urandom_range(CHARS, 1));
    if ($urandom_range(4) == 0)
      for (int i = 0; i < MAX_CHARS; i++)
        w.key_chars[8*i +: 8] = ALPHABET[$urandom_range(3)];
    eff = (w.key_length > CHARS) ? CHARS : w.key_length;
    // a tidy sender zeroes the bytes past the length
    if ($urandom_range(1))
      for (int i = eff; i < MAX_CHARS; i++) w.key_chars[8*i +: 8] = '0;
    return w;
  endfunction

  // Search for a key already inserted, sometimes disguised or altered
  function automatic htlp_pkg::in_word_t recall_word();
    htlp_pkg::in_word_t w;
    int                 eff;
    w      = inserted_q[$urandom_range(inserted_q.size() - 1)];
    w.kind = htlp_pkg::KIND_SEARCH;
    eff    = (w.key_length > CHARS) ? CHARS : w.key_length;
    case ($urandom_range(3))
      0: for (int i = eff; i < MAX_CHARS; i++) w.key_chars[8*i +: 8] = 8'($urandom);
      1: if (eff == CHARS) w.key_length = LEN_W'($urandom_range(15, CHARS));
      2: w.key_length = (eff == CHARS) ? LEN_W'(CHARS - 1) : LEN_W'(eff + 1);
      default: ;
    endcase
    return w;
  endfunction

  // Offer one word, with a random gap first, and note it once accepted
  task automatic send_word(input htlp_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    mirror.note_word(w);
    if (w.kind == htlp_pkg::KIND_INSERT && w.key_length != 0)
      inserted_q = {inserted_q, w};
    sent++;
  endtask

  // Hold the sender off until every owed result has come back
  task automatic hold_for_results();
    start <= 1'b0;
    do @(negedge clk); while (mirror.due_words.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    htlp_pkg::in_word_t w;
    int                 ins_odds;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, then empty keys of both kinds
    send_word(word_of(htlp_pkg::KIND_SEARCH, 64'h0000_0000_0063_6261, 4'd3));
    send_word(word_of(htlp_pkg::KIND_SEARCH, '1, 4'd0));
    send_word(word_of(htlp_pkg::KIND_INSERT, '1, 4'd0));
    // all-ones key at full length, found through an overlong length
    send_word(word_of(htlp_pkg::KIND_INSERT, '1, 4'd8));
    send_word(word_of(htlp_pkg::KIND_SEARCH, '1, 4'd15));
    send_word(word_of(htlp_pkg::KIND_SEARCH, '1, 4'd7));
    // zero byte as a character; stray bytes above the length are ignored
    send_word(word_of(htlp_pkg::KIND_INSERT, 64'h0, 4'd1));
    send_word(word_of(htlp_pkg::KIND_SEARCH, 64'h0, 4'd2));
    send_word(word_of(htlp_pkg::KIND_SEARCH, 64'hFFFF_FFFF_FFFF_FF00, 4'd1));
    // duplicate insert, then a key sharing home slot 0
    send_word(word_of(htlp_pkg::KIND_INSERT, 64'h0, 4'd1));
    send_word(word_of(htlp_pkg::KIND_INSERT, 64'h20, 4'd1));
    send_word(word_of(htlp_pkg::KIND_SEARCH, 64'hA5A5_0000_0000_0020, 4'd1));
    // probe run wrapping from the last slot round to the first
    send_word(word_of(htlp_pkg::KIND_INSERT, 64'h1F, 4'd1));
    send_word(word_of(htlp_pkg::KIND_INSERT, 64'h3F, 4'd1));
    send_word(word_of(htlp_pkg::KIND_SEARCH, 64'h3F, 4'd1));
    // not found after a run of used slots
    send_word(word_of(htlp_pkg::KIND_SEARCH, 64'h80, 4'd1));
    // mixed bytes at full length, overlong insert of an existing key
    send_word(word_of(htlp_pkg::KIND_INSERT, 64'h0123_4567_89AB_CDEF, 4'd8));
    send_word(word_of(htlp_pkg::KIND_SEARCH, 64'h0123_4567_89AB_CDEF, 4'd12));
    send_word(word_of(htlp_pkg::KIND_INSERT, '1, 4'd15));
    send_word(word_of(htlp_pkg::KIND_SEARCH, 64'h0123_4567_89AB_CDEF, 4'd8));

    // Random part: the table fills slowly, then quickly until it is full
    while (sent < N_WORDS) begin
      idle_pct = IDLE_PLAN[(sent / PHASE_WORDS) % 4];
      if (sent == HOLD_A || sent == HOLD_B) hold_for_results();
      ins_odds = (sent < HOLD_B) ? 20 : 3;
      if ($urandom_range(ins_odds - 1) == 0) begin
        if (inserted_q.size() != 0 && $urandom_range(3) == 0)
          w = inserted_q[$urandom_range(inserted_q.size() - 1)];
        else
          w = fresh_word(htlp_pkg::KIND_INSERT);
      end else if (inserted_q.size() != 0 && $urandom_range(9) < 6) begin
        w = recall_word();
      end else begin
        w = fresh_word(htlp_pkg::KIND_SEARCH);
      end
      send_word(w);
    end

    // Let the last results arrive, then watch for strays
    start <= 1'b0;
    do @(negedge clk); while (mirror.due_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
